// File: rtl/unix_seconds_to_calendar_top_defines.svh
// Assertion macros shared by the calendar converter RTL.
// No dependencies; expects clk and arst_n in the including scope.
`ifndef UNIX_SECONDS_TO_CALENDAR_TOP_DEFINES_SVH
`define UNIX_SECONDS_TO_CALENDAR_TOP_DEFINES_SVH

// same-cycle implication, held off during reset
`define UCAL_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, held off during reset
`define UCAL_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/ucal_pkg.sv
// Package for the calendar converter: sequencer states, constants, month table.
// No dependencies.
package ucal_pkg;

	localparam int ACC_W = 17;
	localparam int OPA_W = ACC_W + 1;

	localparam logic [ACC_W-1:0] SECS_PER_DAY  = 17'd86400;
	localparam logic [ACC_W-1:0] SECS_PER_HOUR = 17'd3600;
	localparam logic [ACC_W-1:0] SECS_PER_MIN  = 17'd60;
	localparam logic [ACC_W-1:0] DAYS_COMMON   = 17'd365;
	localparam logic [ACC_W-1:0] DAYS_LEAP     = 17'd366;

	localparam logic [11:0] EPOCH_YEAR  = 12'd1970;
	localparam logic [11:0] LAST_YEAR   = 12'd2106;
	localparam logic [1:0]  EPOCH_MOD4  = 2'd2;
	localparam logic [6:0]  EPOCH_MOD100 = 7'd70;
	localparam logic [8:0]  EPOCH_MOD400 = 9'd370;
	localparam logic [6:0]  MOD100_LAST = 7'd99;
	localparam logic [8:0]  MOD400_LAST = 9'd399;

	localparam logic [3:0] MON_FEB  = 4'd1;
	localparam logic [3:0] MON_LAST = 4'd11;

	// index of the last step of each of the three divisions (quotient width less one)
	localparam logic [4:0] DAYS_LAST_STEP = 5'd15;
	localparam logic [4:0] HOUR_LAST_STEP = 5'd4;
	localparam logic [4:0] MIN_LAST_STEP  = 5'd5;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DAYS,
		ST_HOUR,
		ST_MIN,
		ST_YEAR,
		ST_MONTH,
		ST_DONE
	} state_t;

	function automatic logic [ACC_W-1:0] month_days(input logic [3:0] mon, input logic leap);
		logic [ACC_W-1:0] len;
		begin
			case (mon)
				4'd0:  len = 17'd31;
				4'd1:  len = leap ? 17'd29 : 17'd28;
				4'd2:  len = 17'd31;
				4'd3:  len = 17'd30;
				4'd4:  len = 17'd31;
				4'd5:  len = 17'd30;
				4'd6:  len = 17'd31;
				4'd7:  len = 17'd31;
				4'd8:  len = 17'd30;
				4'd9:  len = 17'd31;
				4'd10: len = 17'd30;
				4'd11: len = 17'd31;
				default: len = 17'd31;
			endcase
			return len;
		end
	endfunction

endpackage

// File: rtl/ucal_sub_unit.sv
// Shared compare-and-subtract unit of the calendar converter.
// Depends on ucal_pkg.
module ucal_sub_unit
	import ucal_pkg::*;
(
	input  logic [OPA_W-1:0] op_a,
	input  logic [ACC_W-1:0] op_b,
	output logic             ge,
	output logic [OPA_W-1:0] diff
);

	logic [OPA_W:0] wide;

	// borrow out of the extended subtract tells a < b
	assign wide = {1'b0, op_a} - {2'b00, op_b};
	assign ge   = ~wide[OPA_W];
	assign diff = wide[OPA_W-1:0];

endmodule

// File: rtl/unix_seconds_to_calendar_top.sv
// Sequence: from input transfer, the day, hour and minute divisions, the year walk from 1970
//   and the month walk from January, then the result register loads once the output is free.
// Takes a new input only when idle; the single compare-subtract unit serves three
//   restoring divisions, the year walk and the month walk in turn.
// Reset (arst_n, async): sequencer to idle, result valid cleared; no clearing pass.
// Files: ucal_pkg, ucal_sub_unit, unix_seconds_to_calendar_top_defines.svh.
`include "unix_seconds_to_calendar_top_defines.svh"

module unix_seconds_to_calendar_top
	import ucal_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [31:0] epoch_seconds,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [11:0] cal_year,
	output logic [3:0]  cal_month,
	output logic [4:0]  cal_day,
	output logic [4:0]  cal_hour,
	output logic [5:0]  cal_minute,
	output logic [5:0]  cal_second
);

	// sequencer
	state_t state_q, state_d;
	logic [4:0] cnt_q;

	// division datapath: partial remainder, dividend bits still to shift in, quotient
	logic [ACC_W-1:0] acc_q;
	logic [31:0]      num_q;
	logic [15:0]      quo_q;

	// time-of-day and date registers
	logic [15:0] days_q;
	logic [4:0]  hour_q;
	logic [5:0]  minute_q;
	logic [5:0]  second_q;
	logic [11:0] yr_q;
	logic [1:0]  m4_q;
	logic [6:0]  m100_q;
	logic [8:0]  m400_q;
	logic [3:0]  mon_q;

	// result register
	logic        out_valid_q;
	logic [11:0] year_q;
	logic [3:0]  month_q;
	logic [4:0]  day_q;
	logic [4:0]  hr_out_q;
	logic [5:0]  min_out_q;
	logic [5:0]  sec_out_q;

	// shared unit hookup
	logic [OPA_W-1:0] op_a;
	logic [ACC_W-1:0] op_b;
	logic             ge;
	logic [OPA_W-1:0] diff;
	logic [OPA_W-1:0] trial;
	logic [ACC_W-1:0] step_rem;
	logic [15:0]      step_quo;
	logic             leap;
	logic             in_xfer;
	logic             out_load;
	logic             div_done;

	assign in_xfer  = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign leap     = ((m4_q == 2'd0) && (m100_q != 7'd0)) || (m400_q == 9'd0);

	// one restoring-division step: bring down the next dividend bit
	assign trial    = {acc_q, num_q[31]};
	assign step_rem = ge ? diff[ACC_W-1:0] : trial[ACC_W-1:0];
	assign step_quo = {quo_q[14:0], ge};

	// operand select for the shared unit
	always_comb begin
		op_a = trial;
		op_b = SECS_PER_DAY;
		case (state_q)
			ST_DAYS:  op_b = SECS_PER_DAY;
			ST_HOUR:  op_b = SECS_PER_HOUR;
			ST_MIN:   op_b = SECS_PER_MIN;
			ST_YEAR: begin
				op_a = {2'b00, days_q};
				op_b = leap ? DAYS_LEAP : DAYS_COMMON;
			end
			ST_MONTH: begin
				op_a = {2'b00, days_q};
				op_b = month_days(mon_q, leap);
			end
			default: begin
				op_a = trial;
				op_b = SECS_PER_DAY;
			end
		endcase
	end

	ucal_sub_unit u_sub (
		.op_a (op_a),
		.op_b (op_b),
		.ge   (ge),
		.diff (diff)
	);

	// next state; the result register loads once the previous result has left
	always_comb begin
		state_d  = state_q;
		out_load = 1'b0;
		div_done = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer) state_d = ST_DAYS;
			end
			ST_DAYS: begin
				div_done = (cnt_q == DAYS_LAST_STEP);
				if (div_done) state_d = ST_HOUR;
			end
			ST_HOUR: begin
				div_done = (cnt_q == HOUR_LAST_STEP);
				if (div_done) state_d = ST_MIN;
			end
			ST_MIN: begin
				div_done = (cnt_q == MIN_LAST_STEP);
				if (div_done) state_d = ST_YEAR;
			end
			ST_YEAR: begin
				if (!ge) state_d = ST_MONTH;
			end
			ST_MONTH: begin
				if (!ge || (mon_q == MON_LAST)) state_d = ST_DONE;
			end
			ST_DONE: begin
				out_load = !out_valid_q || !out_stall;
				if (out_load) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// datapath, no reset needed
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				// seconds/86400: top 16 bits are below the divisor, 16 steps remain
				acc_q <= {1'b0, epoch_seconds[31:16]};
				num_q <= {epoch_seconds[15:0], 16'd0};
				quo_q <= 16'd0;
				cnt_q <= 5'd0;
			end
			ST_DAYS, ST_HOUR, ST_MIN: begin
				if (div_done) begin
					cnt_q <= 5'd0;
					quo_q <= 16'd0;
					case (state_q)
						ST_DAYS: begin
							days_q <= step_quo;
							// second of day / 3600: quotient below 24, 5 steps
							acc_q  <= {5'd0, step_rem[16:5]};
							num_q  <= {step_rem[4:0], 27'd0};
						end
						ST_HOUR: begin
							hour_q <= step_quo[4:0];
							// remainder / 60: quotient below 60, 6 steps
							acc_q  <= {11'd0, step_rem[11:6]};
							num_q  <= {step_rem[5:0], 26'd0};
						end
						default: begin
							minute_q <= step_quo[5:0];
							second_q <= step_rem[5:0];
							yr_q     <= EPOCH_YEAR;
							m4_q     <= EPOCH_MOD4;
							m100_q   <= EPOCH_MOD100;
							m400_q   <= EPOCH_MOD400;
						end
					endcase
				end else begin
					acc_q <= step_rem;
					num_q <= {num_q[30:0], 1'b0};
					quo_q <= step_quo;
					cnt_q <= cnt_q + 5'd1;
				end
			end
			ST_YEAR: begin
				mon_q <= 4'd0;
				if (ge) begin
					days_q <= diff[15:0];
					yr_q   <= yr_q + 12'd1;
					m4_q   <= m4_q + 2'd1;
					m100_q <= (m100_q == MOD100_LAST) ? 7'd0 : m100_q + 7'd1;
					m400_q <= (m400_q == MOD400_LAST) ? 9'd0 : m400_q + 9'd1;
				end
			end
			ST_MONTH: begin
				if (ge && (mon_q != MON_LAST)) begin
					days_q <= diff[15:0];
					mon_q  <= mon_q + 4'd1;
				end
			end
			ST_DONE: begin
				if (out_load) begin
					year_q    <= yr_q;
					month_q   <= mon_q + 4'd1;
					day_q     <= days_q[4:0] + 5'd1;
					hr_out_q  <= hour_q;
					min_out_q <= minute_q;
					sec_out_q <= second_q;
				end
			end
			default: begin
				cnt_q <= 5'd0;
			end
		endcase
	end

	assign out_valid  = out_valid_q;
	assign cal_year   = year_q;
	assign cal_month  = month_q;
	assign cal_day    = day_q;
	assign cal_hour   = hr_out_q;
	assign cal_minute = min_out_q;
	assign cal_second = sec_out_q;

	// a transfer always starts the day division
	`UCAL_ASSERT_NEXT(a_start_days, in_xfer, state_q == ST_DAYS, "transfer did not start division")
	// the partial remainder stays below the hour divisor during the hour division
	`UCAL_ASSERT_NOW(a_rem_day, state_q == ST_HOUR, acc_q < SECS_PER_HOUR, "hour remainder too large")
	// month walk never runs past December, and the year walk stays in range
	`UCAL_ASSERT_NOW(a_mon_range, state_q == ST_MONTH, mon_q <= MON_LAST && yr_q <= LAST_YEAR,
		"month or year out of range")
	// after the month walk the day of month fits its field
	`UCAL_ASSERT_NOW(a_day_fits, state_q == ST_DONE, days_q < 16'd31, "day of month overflow")

endmodule
